[sv/fdbb_pkg.sv]
// ----------------------------------------------------------------------------
// fdbb_pkg
// Shared types, constants and helpers of the frame difference bounding box.
// ----------------------------------------------------------------------------
`default_nettype none

package fdbb_pkg;

	// Field widths
	localparam int PIX_W   = 32;
	localparam int CFG_W   = 13;
	localparam int LEFT_W  = 12;
	localparam int SPAN_W  = 13;
	localparam int CFG_MAX = (1 << CFG_W) - 1;

	// Default frame limit and register reset values
	localparam int DEFAULT_MAX_DIM = 4096;
	localparam int RESET_WIDTH     = 640;
	localparam int RESET_HEIGHT    = 480;

	// Register indexes on the configuration port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	// One input transaction: a reference pixel and the new pixel at the same place
	typedef struct packed {
		logic [PIX_W-1:0] old_pixel;
		logic [PIX_W-1:0] new_pixel;
	} pix_pair_t;

	// One result transaction: the rectangle enclosing all differences of a frame
	typedef struct packed {
		logic              changed;
		logic [LEFT_W-1:0] rect_left;
		logic [LEFT_W-1:0] rect_top;
		logic [SPAN_W-1:0] rect_width;
		logic [SPAN_W-1:0] rect_height;
	} box_t;

	// Size as used by the position counters: zero acts as one, large values clamp
	function automatic logic [CFG_W-1:0] eff_size(input logic [CFG_W-1:0] v, input int max_dim);
		logic [CFG_W-1:0] r;
		begin
			if (v == '0) begin
				r = CFG_W'(1);
			end else if (32'(v) > max_dim) begin
				r = CFG_W'(max_dim);
			end else begin
				r = v;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

[sv/frame_diff_bounding_box.sv]
// ----------------------------------------------------------------------------
// frame_diff_bounding_box
// Streams pixel pairs of two frames and reports the bounding box of changes.
// ----------------------------------------------------------------------------
// Takes one pixel pair per clock in raster order (column fastest) and keeps the
// smallest and largest column and row at which the two pixels differ. After the
// last pixel of a frame one result transaction carries the enclosing rectangle,
// or changed = 0 with a zero rectangle, and tracking restarts at column 0, row 0.
// Throughput is one pixel pair per cycle while pix_ready is high. The pixel
// register feeds the tracking update and the result register, which is loaded
// when a frame-end pixel leaves the pixel register; pix_ready drops only while
// a frame-end pixel waits for a result register that still holds an untaken
// result. Frame size is set through cfg_write/cfg_index/cfg_data; the user is
// to write it only while no pixel is held in the block, which the block itself
// does not enforce. A size of 0 acts as 1 and sizes above MAX_DIM act as
// MAX_DIM. A size change part way through a frame keeps the scan position, so
// a shrunk size ends the row or the frame at the next pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_diff_bounding_box
	import fdbb_pkg::*;
#(
	parameter int MAX_DIM = DEFAULT_MAX_DIM
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// pixel pairs
	input  wire logic                 pix_valid,
	output logic                      pix_ready,
	input  wire pix_pair_t            pix,
	// results
	output logic                      box_valid,
	input  wire logic                 box_ready,
	output box_t                      box
);

	// Positions never exceed the smaller of MAX_DIM and the largest register value
	localparam int EFF_MAX = (MAX_DIM < CFG_MAX) ? MAX_DIM : CFG_MAX;
	localparam int POS_W   = $clog2(EFF_MAX);
	localparam int CMP_W   = CFG_W + 1;

	logic [CFG_W-1:0] width_q, height_q;

	logic             valid_s1;
	pix_pair_t        pix_s1;

	logic [POS_W-1:0] col_q, row_q;
	logic [POS_W-1:0] min_col_q, max_col_q, min_row_q, max_row_q;
	logic             any_q;

	logic [POS_W-1:0] min_col_n, max_col_n, min_row_n, max_row_n;
	logic             any_n;
	logic             diff;
	logic             col_end, row_end, frame_end;
	logic             advance;

	box_t             box_q;
	logic             box_valid_q;
	box_t             box_n;
	logic [POS_W:0]   span_col, span_row;

	// Configuration registers hold the effective size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= eff_size(CFG_W'(RESET_WIDTH), MAX_DIM);
			height_q <= eff_size(CFG_W'(RESET_HEIGHT), MAX_DIM);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  width_q  <= eff_size(cfg_data, MAX_DIM);
				REG_FRAME_HEIGHT: height_q <= eff_size(cfg_data, MAX_DIM);
				default: ;
			endcase
		end
	end

	// Frame end stalls only when the result register is still occupied
	assign advance   = valid_s1 && (!frame_end || !box_valid_q || box_ready);
	assign pix_ready = !valid_s1 || advance;

	// Pixel input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_ready) begin
			valid_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_ready && pix_valid) begin
			pix_s1 <= pix;
		end
	end

	// Extent update including the current pixel
	always_comb begin
		diff      = (pix_s1.old_pixel != pix_s1.new_pixel);
		min_col_n = min_col_q;
		max_col_n = max_col_q;
		min_row_n = min_row_q;
		max_row_n = max_row_q;
		any_n     = any_q;
		if (diff) begin
			any_n = 1'b1;
			if (!any_q) begin
				min_col_n = col_q;
				max_col_n = col_q;
				min_row_n = row_q;
				max_row_n = row_q;
			end else begin
				if (col_q < min_col_q) min_col_n = col_q;
				if (col_q > max_col_q) max_col_n = col_q;
				if (row_q < min_row_q) min_row_n = row_q;
				if (row_q > max_row_q) max_row_n = row_q;
			end
		end
	end

	// Row and frame end; a shrunk size ends at the next pixel
	assign col_end   = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(width_q);
	assign row_end   = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(height_q);
	assign frame_end = col_end && row_end;

	// Tracking state and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			any_q     <= 1'b0;
		end else if (advance) begin
			if (frame_end) begin
				col_q     <= '0;
				row_q     <= '0;
				min_col_q <= '0;
				max_col_q <= '0;
				min_row_q <= '0;
				max_row_q <= '0;
				any_q     <= 1'b0;
			end else begin
				min_col_q <= min_col_n;
				max_col_q <= max_col_n;
				min_row_q <= min_row_n;
				max_row_q <= max_row_n;
				any_q     <= any_n;
				if (col_end) begin
					col_q <= '0;
					row_q <= row_q + POS_W'(1);
				end else begin
					col_q <= col_q + POS_W'(1);
				end
			end
		end
	end

	// Result of a frame; zero rectangle when nothing changed
	always_comb begin
		span_col = (POS_W+1)'(max_col_n) - (POS_W+1)'(min_col_n) + (POS_W+1)'(1);
		span_row = (POS_W+1)'(max_row_n) - (POS_W+1)'(min_row_n) + (POS_W+1)'(1);
		box_n    = '0;
		if (any_n) begin
			box_n.changed     = 1'b1;
			box_n.rect_left   = LEFT_W'(min_col_n);
			box_n.rect_top    = LEFT_W'(min_row_n);
			box_n.rect_width  = SPAN_W'(span_col);
			box_n.rect_height = SPAN_W'(span_row);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q <= 1'b0;
		end else if (advance && frame_end) begin
			box_valid_q <= 1'b1;
		end else if (box_ready) begin
			box_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame_end) begin
			box_q <= box_n;
		end
	end

	assign box_valid = box_valid_q;
	assign box       = box_q;

endmodule

`default_nettype wire

[sv/fdbb_checker.sv]
// ----------------------------------------------------------------------------
// fdbb_checker
// Port-level checks of the frame difference bounding box, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module fdbb_checker
	import fdbb_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      pix_valid,
	input wire logic      pix_ready,
	input wire logic      box_valid,
	input wire logic      box_ready,
	input wire box_t      box
);

	// An unchanged frame reports an all-zero rectangle
	a_unchanged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && !box.changed) |->
			(box.rect_left == '0 && box.rect_top == '0 &&
			 box.rect_width == '0 && box.rect_height == '0))
		else $error("unchanged frame with non-zero rectangle");

	// A changed frame spans at least one pixel each way
	a_changed_span: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && box.changed) |->
			(box.rect_width != '0 && box.rect_height != '0))
		else $error("changed frame with empty rectangle");

	// A new result follows a pixel transaction through the pixel and result registers
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(box_valid) |-> $past(pix_valid && pix_ready, 2))
		else $error("result without a preceding pixel transaction");

	// A waiting result holds still
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(box_valid && !box_ready) |=> (box_valid && $stable(box)))
		else $error("result changed while stalled");

endmodule

bind frame_diff_bounding_box fdbb_checker u_fdbb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.box_valid (box_valid),
	.box_ready (box_ready),
	.box       (box)
);

`default_nettype wire

[sim/frame_diff_bounding_box_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_diff_bounding_box_test
// Self-checking bench for the frame difference bounding box.
// ----------------------------------------------------------------------------
// Pixel pairs are streamed in raster order while a behavioural tracker in the
// bench follows the scan position and the extent of differing pixels. Every
// frame end predicts one box transaction, which is compared field by field
// with what the block returns. Directed tests cover the reset frame size,
// single-pixel frames, oversized and tallest sizes, size changes part way
// through a frame and a long output stall. Random frames of small sizes follow,
// with random gaps on both the pixel and the box side.
// ----------------------------------------------------------------------------

module frame_diff_bounding_box_test;
	import fdbb_pkg::*;

	localparam int DRAIN_CYCLES = 6;
	localparam int IDLE_LIMIT   = 5000;
	localparam int RANDOM_PAIRS = 800;
	localparam int HOLD_CYCLES  = 150;
	localparam int RESET_PAIRS  = RESET_WIDTH + 5;
	localparam int LARGE_PAIRS  = 48;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 pix_valid = 1'b0;
	logic                 pix_ready;
	pix_pair_t            pix       = '0;
	logic                 box_valid;
	logic                 box_ready = 1'b0;
	box_t                 box;

	// Bench tracker: frame size registers and scan/extent state
	logic [CFG_W-1:0] width_reg  = CFG_W'(RESET_WIDTH);
	logic [CFG_W-1:0] height_reg = CFG_W'(RESET_HEIGHT);
	int               col_at     = 0;
	int               row_at     = 0;
	int               col_lo     = 0;
	int               col_hi     = 0;
	int               row_lo     = 0;
	int               row_hi     = 0;
	bit               seen_diff  = 1'b0;
	box_t             expected_boxes[$];

	// Pacing controls of the stimulus and the output side, and the failure count
	bit steady_source = 1'b0;
	bit steady_sink   = 1'b0;
	int sink_hold     = 0;
	int failures      = 0;

	always #5 clk = ~clk;

	frame_diff_bounding_box dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.box_valid (box_valid),
		.box_ready (box_ready),
		.box       (box)
	);

	// Size as the scan counters see it: zero acts as one, clamp at the limit
	function automatic int dim_of(logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > DEFAULT_MAX_DIM)
			return DEFAULT_MAX_DIM;
		return int'(v);
	endfunction

	// Advance the tracker by one pixel pair; queue a box at frame end
	function automatic void track_pair(pix_pair_t p);
		box_t b;
		if (p.old_pixel != p.new_pixel) begin
			if (!seen_diff) begin
				col_lo    = col_at;
				col_hi    = col_at;
				row_lo    = row_at;
				row_hi    = row_at;
				seen_diff = 1'b1;
			end else begin
				if (col_at < col_lo) col_lo = col_at;
				if (col_at > col_hi) col_hi = col_at;
				if (row_at < row_lo) row_lo = row_at;
				if (row_at > row_hi) row_hi = row_at;
			end
		end
		if (col_at + 1 < dim_of(width_reg)) begin
			col_at++;
		end else if (row_at + 1 < dim_of(height_reg)) begin
			col_at = 0;
			row_at++;
		end else begin
			b = '0;
			if (seen_diff) begin
				b.changed     = 1'b1;
				b.rect_left   = LEFT_W'(col_lo);
				b.rect_top    = LEFT_W'(row_lo);
				b.rect_width  = SPAN_W'(col_hi - col_lo + 1);
				b.rect_height = SPAN_W'(row_hi - row_lo + 1);
			end
			expected_boxes = {expected_boxes, b};
			col_at    = 0;
			row_at    = 0;
			col_lo    = 0;
			col_hi    = 0;
			row_lo    = 0;
			row_hi    = 0;
			seen_diff = 1'b0;
		end
	endfunction

	// Random pixel pair; a difference flips one bit, one channel or a random mask
	function automatic pix_pair_t gen_pair(bit differ);
		pix_pair_t        p;
		logic [PIX_W-1:0] flip;
		p.old_pixel = $urandom;
		flip = '0;
		if (differ) begin
			case ($urandom_range(0, 2))
				0: begin
					flip = 32'h1 << $urandom_range(0, 31);
				end
				1: begin
					flip = 32'hFF << (8 * $urandom_range(0, 3));
				end
				default: begin
					do flip = $urandom; while (flip == '0);
				end
			endcase
		end
		p.new_pixel = p.old_pixel ^ flip;
		return p;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int gap_len();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one pixel pair and hold it until the block takes it
	task automatic send_pair(pix_pair_t p);
		int gap;
		gap = (steady_source || $urandom_range(0, 99) < 65) ? 0 : gap_len();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (pix_ready !== 1'b1);
		track_pair(p);
	endtask

	// Write both size registers on consecutive edges
	task automatic set_frame_size(int w, int h);
		cfg_write <= 1'b1;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= CFG_W'(w);
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= CFG_W'(h);
		@(posedge clk);
		cfg_write  <= 1'b0;
		width_reg  = CFG_W'(w);
		height_reg = CFG_W'(h);
	endtask

	// Stop offering pixels until every box is back and the pipeline is empty
	task automatic wait_drained();
		pix_valid <= 1'b0;
		while (expected_boxes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic flag_field(string field, logic [31:0] want_v, logic [31:0] got_v);
		$display("%0t ns: box %s mismatch: expected %0d, got %0d",
			$time, field, want_v, got_v);
		failures++;
	endtask

	// Reset size: the first row wraps after the reset width, then a shrunk
	// size ends the frame early
	task automatic test_reset_size();
		steady_source = 1'b1;
		repeat (RESET_PAIRS)
			send_pair(gen_pair($urandom_range(0, 99) < 2));
		wait_drained();
		set_frame_size(1, 2);
		send_pair(gen_pair($urandom_range(0, 1)));
		wait_drained();
		steady_source = 1'b0;
	endtask

	// Zero size acts as 1x1: every pair is a frame; pixel extremes
	task automatic test_single_pixel_frames();
		pix_pair_t p;
		set_frame_size(0, 0);
		p = '{old_pixel: '0, new_pixel: '0};
		send_pair(p);
		p = '{old_pixel: '1, new_pixel: '1};
		send_pair(p);
		p = '{old_pixel: '0, new_pixel: '1};
		send_pair(p);
		p = '{old_pixel: '1, new_pixel: '0};
		send_pair(p);
		p = '{old_pixel: 32'h8000_0000, new_pixel: 32'h0000_0000};
		send_pair(p);
		p = '{old_pixel: 32'h0000_0001, new_pixel: 32'h0000_0000};
		send_pair(p);
		wait_drained();
	endtask

	// Oversized width: no row end within the first columns, then a shrunk
	// size ends the frame
	task automatic test_wide_frame();
		set_frame_size(CFG_MAX, 0);
		for (int c = 0; c < LARGE_PAIRS; c++)
			send_pair(gen_pair(c == 3 || c == LARGE_PAIRS - 8));
		wait_drained();
		set_frame_size(1, 1);
		send_pair(gen_pair(1'b0));
		wait_drained();
	endtask

	// Tallest size: one column, changes in the first and a late row, then a
	// shrunk size ends the frame
	task automatic test_tall_frame();
		set_frame_size(1, DEFAULT_MAX_DIM);
		for (int r = 0; r < LARGE_PAIRS; r++)
			send_pair(gen_pair(r == 0 || r == LARGE_PAIRS - 1));
		wait_drained();
		set_frame_size(1, 1);
		send_pair(gen_pair(1'b0));
		wait_drained();
	endtask

	// Shrink the size part way through a frame; row and frame end early
	task automatic test_mid_frame_resize();
		set_frame_size(5, 4);
		repeat (7) send_pair(gen_pair($urandom_range(0, 1)));
		wait_drained();
		set_frame_size(2, 4);
		repeat (3) send_pair(gen_pair($urandom_range(0, 1)));
		wait_drained();
		set_frame_size(1, 1);
		send_pair(gen_pair(1'b1));
		wait_drained();
	endtask

	// Output held off while pixels keep coming, so the input must stall
	task automatic test_backpressure();
		set_frame_size(1, 1);
		steady_source = 1'b1;
		sink_hold     = HOLD_CYCLES;
		repeat (60) send_pair(gen_pair($urandom_range(0, 1)));
		wait_drained();
		steady_source = 1'b0;
	endtask

	// Random small frames, sizes changed at random scan positions
	task automatic test_random_frames();
		int sent;
		int w;
		int h;
		int diff_pct;
		int count;
		sent = 0;
		while (sent < RANDOM_PAIRS) begin
			w = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 24);
			h = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 24);
			set_frame_size(w, h);
			steady_source = ($urandom_range(0, 4) == 0);
			steady_sink   = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
				0: diff_pct = 0;
				1: diff_pct = 3;
				2: diff_pct = 25;
				default: diff_pct = 100;
			endcase
			count = $urandom_range(1, 3 * dim_of(CFG_W'(w)) * dim_of(CFG_W'(h)) + 2);
			if (count > 200)
				count = 200;
			repeat (count) send_pair(gen_pair($urandom_range(0, 99) < diff_pct));
			sent += count;
			wait_drained();
		end
		steady_source = 1'b0;
		steady_sink   = 1'b0;
	endtask

	// Test sequence
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_single_pixel_frames();
		test_wide_frame();
		test_tall_frame();
		test_mid_frame_resize();
		test_backpressure();
		test_random_frames();
		wait_drained();
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Box side: random stalls, plus a long hold when a test asks for one
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				box_ready <= 1'b0;
			end else if (sink_hold > 0) begin
				stall_left = sink_hold - 1;
				sink_hold  = 0;
				box_ready <= 1'b0;
			end else if (!steady_sink && $urandom_range(0, 99) < 30) begin
				stall_left = gap_len() - 1;
				box_ready <= 1'b0;
			end else begin
				box_ready <= 1'b1;
			end
		end
	end

	// Compare each box transaction with the oldest prediction
	initial begin
		box_t want;
		forever begin
			@(posedge clk);
			if (arst_n && box_valid === 1'b1 && box_ready) begin
				if (expected_boxes.size() == 0) begin
					$display("%0t ns: unexpected box: expected none, got %p", $time, box);
					failures++;
				end else begin
					want = expected_boxes[0];
					expected_boxes.delete(0);
					if (box.changed !== want.changed)
						flag_field("changed", 32'(want.changed), 32'(box.changed));
					if (box.rect_left !== want.rect_left)
						flag_field("rect_left", 32'(want.rect_left), 32'(box.rect_left));
					if (box.rect_top !== want.rect_top)
						flag_field("rect_top", 32'(want.rect_top), 32'(box.rect_top));
					if (box.rect_width !== want.rect_width)
						flag_field("rect_width", 32'(want.rect_width),
							32'(box.rect_width));
					if (box.rect_height !== want.rect_height)
						flag_field("rect_height", 32'(want.rect_height),
							32'(box.rect_height));
				end
			end
		end
	end

	// Watchdog: too long without any transaction on either side
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && pix_ready === 1'b1) || (box_valid === 1'b1 && box_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule

[files.f]
sv/fdbb_pkg.sv
sv/frame_diff_bounding_box.sv
sv/fdbb_checker.sv
sim/frame_diff_bounding_box_test.sv
